// ----- design/tlc_pkg.sv -----
`timescale 1ns / 1ps
package tlc_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int MAX_ZOOM = 19;
	localparam int XY_W = 19;
	localparam int AGE_W = 32;

	localparam logic CMD_SEARCH = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	localparam logic [2:0] ST_MISS = 3'd0;
	localparam logic [2:0] ST_HIT = 3'd1;
	localparam logic [2:0] ST_REJECT = 3'd2;
	localparam logic [2:0] ST_REPLACED = 3'd3;
	localparam logic [2:0] ST_FREE = 3'd4;
	localparam logic [2:0] ST_EVICT = 3'd5;

	localparam logic [2:0] REG_CAPACITY_ADDR = 3'd0;

	typedef struct packed {
		logic        command;
		logic [4:0]  zoom;
		logic [31:0] tile_x;
		logic [31:0] tile_y;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot_index;
		logic [4:0]  found_zoom;
		logic [18:0] found_x;
		logic [18:0] found_y;
	} out_item_t;

	typedef struct packed {
		logic            ok;
		logic [4:0]      zoom;
		logic [XY_W-1:0] x;
		logic [XY_W-1:0] y;
	} key_t;

	typedef struct packed {
		logic             tag_en;
		logic             age_en;
		logic [IDX_W-1:0] idx;
		logic [4:0]       zoom;
		logic [XY_W-1:0]  x;
		logic [XY_W-1:0]  y;
		logic [AGE_W-1:0] age;
	} wr_t;

	typedef struct packed {
		logic             have;
		logic [AGE_W-1:0] lag;
		logic [IDX_W-1:0] idx;
	} vic_t;

endpackage

// ----- design/tlc_cell.sv -----
`timescale 1ns / 1ps
module tlc_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [tlc_pkg::IDX_W-1:0]         my_idx,
	input  tlc_pkg::key_t                     key,
	input  tlc_pkg::wr_t                      wr,
	input  logic [tlc_pkg::AGE_W-1:0]         now,
	input  tlc_pkg::vic_t                     vic_in,
	output tlc_pkg::vic_t                     vic_out,
	output logic                              match
);

	logic                        valid_q;
	logic [4:0]                  zoom_q;
	logic [tlc_pkg::XY_W-1:0]    x_q;
	logic [tlc_pkg::XY_W-1:0]    y_q;
	logic [tlc_pkg::AGE_W-1:0]   age_q;
	logic                        match_q;
	tlc_pkg::vic_t               vic_q;
	logic [tlc_pkg::AGE_W-1:0]   lag;
	logic                        sel;

	assign lag = now - age_q;
	assign sel = valid_q && (!vic_in.have || lag > vic_in.lag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			vic_q <= '0;
		end else begin
			if (wr.tag_en && wr.idx == my_idx) begin
				valid_q <= 1'b1;
			end
			match_q <= valid_q && key.ok && zoom_q == key.zoom && x_q == key.x
				&& y_q == key.y;
			if (sel) begin
				vic_q <= '{have: 1'b1, lag: lag, idx: my_idx};
			end else begin
				vic_q <= vic_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.tag_en && wr.idx == my_idx) begin
			zoom_q <= wr.zoom;
			x_q <= wr.x;
			y_q <= wr.y;
		end
		if (wr.age_en && wr.idx == my_idx) begin
			age_q <= wr.age;
		end
	end

	assign vic_out = vic_q;
	assign match = match_q;

endmodule

// ----- design/tile_lru_cache_with_parent_fallback.sv -----
`timescale 1ns / 1ps
// tag manager for a fully associative tile cache of 64 entries held in a row of cells;
// a search tries its zoom level and then each parent level down to zoom 0 until it
// hits, and an insert into a full cache scans for the least recently used entry,
// found by letting the age comparison ripple down the 64-cell row, one cell per
// cycle; one item is worked on at a time and the result sits in an output register,
// so the next item is taken while it waits
module tile_lru_cache_with_parent_fallback (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tlc_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output tlc_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_PUT = 3'd4;

	logic [2:0]                     state_q;
	logic                           cmd_q;
	logic [4:0]                     z_q;
	logic [31:0]                    x_q;
	logic [31:0]                    y_q;
	logic [6:0]                     cap_q;
	logic [tlc_pkg::CNT_W-1:0]      used_q;
	logic [tlc_pkg::CNT_W-1:0]      cnt_q;
	logic [tlc_pkg::AGE_W-1:0]      clock_q;
	tlc_pkg::wr_t                   wr_q;
	tlc_pkg::out_item_t             res_q;
	tlc_pkg::out_item_t             out_q;
	logic                           out_valid_q;
	tlc_pkg::key_t                  key;
	tlc_pkg::vic_t                  chain [tlc_pkg::CAPACITY+1];
	logic [tlc_pkg::CAPACITY-1:0]   match;
	logic                           hit;
	logic [tlc_pkg::IDX_W-1:0]      hit_idx;
	logic [tlc_pkg::CNT_W-1:0]      eff_cap;
	logic                           out_free;
	logic                           bad_insert;
	logic                           wr_set;

	assign key.ok = x_q[31:tlc_pkg::XY_W] == '0 && y_q[31:tlc_pkg::XY_W] == '0;
	assign key.zoom = z_q;
	assign key.x = x_q[tlc_pkg::XY_W-1:0];
	assign key.y = y_q[tlc_pkg::XY_W-1:0];
	assign chain[0] = '0;

	for (genvar i = 0; i < tlc_pkg::CAPACITY; i++) begin : g_cell
		tlc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.my_idx  (tlc_pkg::IDX_W'(i)),
			.key     (key),
			.wr      (wr_q),
			.now     (clock_q),
			.vic_in  (chain[i]),
			.vic_out (chain[i+1]),
			.match   (match[i])
		);
	end

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < tlc_pkg::CAPACITY; i++) begin
			hit_idx = hit_idx | (match[i] ? tlc_pkg::IDX_W'(i) : '0);
		end
	end
	assign hit = |match;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = tlc_pkg::CNT_W'(1);
		end else if ({1'b0, cap_q} > 8'(tlc_pkg::CAPACITY)) begin
			eff_cap = tlc_pkg::CNT_W'(tlc_pkg::CAPACITY);
		end else begin
			eff_cap = tlc_pkg::CNT_W'(cap_q);
		end
	end

	assign bad_insert = in_item.zoom > 5'(tlc_pkg::MAX_ZOOM)
		|| (in_item.tile_x >> in_item.zoom) != '0 || (in_item.tile_y >> in_item.zoom) != '0;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != S_IDLE;
	assign wr_set = (state_q == S_CHECK
		&& (hit || (cmd_q == tlc_pkg::CMD_INSERT && used_q < eff_cap)))
		|| (state_q == S_SCAN && cnt_q == tlc_pkg::CNT_W'(tlc_pkg::CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= 7'd64;
			used_q <= '0;
			cnt_q <= '0;
			clock_q <= '0;
			wr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!wr_set) begin
				wr_q.tag_en <= 1'b0;
				wr_q.age_en <= 1'b0;
			end
			if (psel && penable && pwrite && paddr == tlc_pkg::REG_CAPACITY_ADDR) begin
				cap_q <= pwdata[6:0];
			end
			if (state_q == S_PUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= in_item.command;
						z_q <= in_item.zoom;
						x_q <= in_item.tile_x;
						y_q <= in_item.tile_y;
						if (in_item.command == tlc_pkg::CMD_SEARCH
							&& in_item.zoom > 5'(tlc_pkg::MAX_ZOOM)) begin
							res_q <= '{status: tlc_pkg::ST_MISS, default: '0};
							state_q <= S_PUT;
						end else if (in_item.command == tlc_pkg::CMD_INSERT && bad_insert) begin
							res_q <= '{status: tlc_pkg::ST_REJECT, default: '0};
							state_q <= S_PUT;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (hit) begin
						clock_q <= clock_q + 1'b1;
						wr_q <= '{tag_en: 1'b0, age_en: 1'b1, idx: hit_idx,
							zoom: z_q, x: x_q[18:0], y: y_q[18:0], age: clock_q + 1'b1};
						res_q <= '{status: (cmd_q == tlc_pkg::CMD_INSERT) ?
							tlc_pkg::ST_REPLACED : tlc_pkg::ST_HIT,
							slot_index: hit_idx, found_zoom: z_q,
							found_x: x_q[18:0], found_y: y_q[18:0]};
						state_q <= S_PUT;
					end else if (cmd_q == tlc_pkg::CMD_SEARCH) begin
						if (z_q == '0) begin
							res_q <= '{status: tlc_pkg::ST_MISS, default: '0};
							state_q <= S_PUT;
						end else begin
							z_q <= z_q - 1'b1;
							x_q <= x_q >> 1;
							y_q <= y_q >> 1;
							state_q <= S_LOOK;
						end
					end else if (used_q >= eff_cap) begin
						cnt_q <= '0;
						state_q <= S_SCAN;
					end else begin
						clock_q <= clock_q + 1'b1;
						wr_q <= '{tag_en: 1'b1, age_en: 1'b1, idx: used_q[tlc_pkg::IDX_W-1:0],
							zoom: z_q, x: x_q[18:0], y: y_q[18:0], age: clock_q + 1'b1};
						used_q <= used_q + 1'b1;
						res_q <= '{status: tlc_pkg::ST_FREE,
							slot_index: used_q[tlc_pkg::IDX_W-1:0], found_zoom: z_q,
							found_x: x_q[18:0], found_y: y_q[18:0]};
						state_q <= S_PUT;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tlc_pkg::CNT_W'(tlc_pkg::CAPACITY)) begin
						clock_q <= clock_q + 1'b1;
						wr_q <= '{tag_en: 1'b1, age_en: 1'b1,
							idx: chain[tlc_pkg::CAPACITY].idx,
							zoom: z_q, x: x_q[18:0], y: y_q[18:0], age: clock_q + 1'b1};
						res_q <= '{status: tlc_pkg::ST_EVICT,
							slot_index: chain[tlc_pkg::CAPACITY].idx, found_zoom: z_q,
							found_x: x_q[18:0], found_y: y_q[18:0]};
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						out_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign prdata = {25'd0, cap_q};
	assign pready = 1'b1;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= tlc_pkg::CNT_W'(tlc_pkg::CAPACITY))
		else $error("fill count above capacity");
	a_tag_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one tag matched");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == tlc_pkg::ST_REJECT |-> out_item.slot_index == '0)
		else $error("rejected item carries a slot");

endmodule
